@@ design/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");

`endif

@@ design/rhsv_pkg.sv @@
package rhsv_pkg;

   localparam int COMP_W    = 8;                      // color component width
   localparam int HUE_W     = 9;                      // hue result width
   localparam int NUM_W     = 17;                     // dividend width
   localparam int QUOT_W    = 9;                      // quotient bits per divide
   localparam int DIV_STAGES = 3;                     // divider pipeline stages
   localparam int DIV_STEPS = QUOT_W / DIV_STAGES;    // quotient bits per stage

   localparam logic [NUM_W-1:0] HUE_RED_WRAP = NUM_W'(360);
   localparam logic [NUM_W-1:0] HUE_GREEN_BASE = NUM_W'(120);
   localparam logic [NUM_W-1:0] HUE_BLUE_BASE = NUM_W'(240);
   localparam logic signed [15:0] HUE_SECTOR = 16'sd60;

   // Sector codes: which component holds the maximum
   localparam logic [1:0] SECT_RED   = 2'd0;
   localparam logic [1:0] SECT_GREEN = 2'd1;
   localparam logic [1:0] SECT_BLUE  = 2'd2;

   // One long-division lane: partial remainder, shift word, divisor.
   // The shift word starts as the low dividend bits and ends as the quotient.
   typedef struct packed {
      logic [COMP_W-1:0] rem;
      logic [QUOT_W-1:0] work;
      logic [COMP_W-1:0] divisor;
   } div_lane_type;

   // Data that travels through the divider stages
   typedef struct packed {
      logic              valid;
      logic              grey;
      logic [COMP_W-1:0] brightness;
      div_lane_type      hue;
      div_lane_type      sat;
   } div_pipe_type;

   // Start a lane from a dividend known to give a quotient below 2**QUOT_W
   function automatic div_lane_type div_load(logic [NUM_W-1:0] num,
                                             logic [COMP_W-1:0] divisor);
      div_lane_type l;
      l.rem     = num[NUM_W-1:QUOT_W];
      l.work    = num[QUOT_W-1:0];
      l.divisor = divisor;
      return l;
   endfunction

   // One restoring division step: bring down a bit, trial subtract
   function automatic div_lane_type div_step(div_lane_type l);
      logic [COMP_W:0] trial;
      div_lane_type    r;
      trial = {l.rem, l.work[QUOT_W-1]};
      r     = l;
      if (trial >= {1'b0, l.divisor}) begin
         r.rem  = COMP_W'(trial - {1'b0, l.divisor});
         r.work = {l.work[QUOT_W-2:0], 1'b1};
      end else begin
         r.rem  = trial[COMP_W-1:0];
         r.work = {l.work[QUOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

@@ design/rgb_to_hsv_pixel_top.sv @@
// Channel   Handshake            Ports
// request   start (busy = 0)     req_red, req_green, req_blue
// response  rsp_valid strobe     rsp_hue, rsp_saturation, rsp_brightness
//
// One pixel enters per cycle; busy is always low.
// Results pass through classify, dividend forming, then three divider
// stages that each resolve three quotient bits of both divides.
// Synchronous reset clears only the valid bits; no result follows reset.
// The receiver cannot stall: each result shows for one cycle only.
module rgb_to_hsv_pixel_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rhsv_pkg::COMP_W-1:0]   req_red,
   input  logic [rhsv_pkg::COMP_W-1:0]   req_green,
   input  logic [rhsv_pkg::COMP_W-1:0]   req_blue,
   output logic                          rsp_valid,
   output logic [rhsv_pkg::HUE_W-1:0]    rsp_hue,
   output logic [rhsv_pkg::COMP_W-1:0]   rsp_saturation,
   output logic [rhsv_pkg::COMP_W-1:0]   rsp_brightness
);

   rhsv_pkg::div_pipe_type pipe [rhsv_pkg::DIV_STAGES+1];

   // Fully pipelined: never hold off a transaction
   assign busy = 1'b0;

   rhsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .out      (pipe[0])
   );

   for (genvar s = 0; s < rhsv_pkg::DIV_STAGES; s++) begin : g_div
      rhsv_div_stage u_stage (
         .clock (clock),
         .reset (reset),
         .in    (pipe[s]),
         .out   (pipe[s+1])
      );
   end

   // Drive the result; force hue and saturation to zero for grey
   always_comb begin
      rsp_valid      = pipe[rhsv_pkg::DIV_STAGES].valid;
      rsp_brightness = pipe[rhsv_pkg::DIV_STAGES].brightness;
      if (pipe[rhsv_pkg::DIV_STAGES].grey) begin
         rsp_hue        = '0;
         rsp_saturation = '0;
      end else begin
         rsp_hue        = pipe[rhsv_pkg::DIV_STAGES].hue.work;
         rsp_saturation = pipe[rhsv_pkg::DIV_STAGES].sat.work[rhsv_pkg::COMP_W-1:0];
      end
   end

endmodule

@@ design/rhsv_front.sv @@
module rhsv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rhsv_pkg::COMP_W-1:0]   red,
   input  logic [rhsv_pkg::COMP_W-1:0]   green,
   input  logic [rhsv_pkg::COMP_W-1:0]   blue,
   output rhsv_pkg::div_pipe_type        out
);

   // Stage 1 registers: max, delta, sector, signed difference
   logic                          s1_valid_ff;
   logic [rhsv_pkg::COMP_W-1:0]   s1_max_ff, s1_max_in;
   logic [rhsv_pkg::COMP_W-1:0]   s1_delta_ff, s1_delta_in;
   logic [1:0]                    s1_sector_ff, s1_sector_in;
   logic signed [rhsv_pkg::COMP_W:0] s1_diff_ff, s1_diff_in;

   logic [rhsv_pkg::COMP_W-1:0]   min_val;

   // Stage 2 register: divider inputs
   logic                          s2_valid_ff;
   rhsv_pkg::div_pipe_type        s2_ff, s2_in;

   logic [rhsv_pkg::NUM_W-1:0]    base;
   logic signed [15:0]            diff_x;
   logic signed [15:0]            diff_scaled;
   logic signed [rhsv_pkg::NUM_W:0] hue_sum;
   logic [rhsv_pkg::NUM_W-1:0]    hue_num;
   logic [rhsv_pkg::NUM_W-1:0]    sat_num;

   // Classify: red wins ties over green, green over blue
   always_comb begin
      if (red >= green && red >= blue) begin
         s1_sector_in = rhsv_pkg::SECT_RED;
         s1_max_in    = red;
         s1_diff_in   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green >= blue) begin
         s1_sector_in = rhsv_pkg::SECT_GREEN;
         s1_max_in    = green;
         s1_diff_in   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         s1_sector_in = rhsv_pkg::SECT_BLUE;
         s1_max_in    = blue;
         s1_diff_in   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
      min_val = red;
      if (green < min_val) min_val = green;
      if (blue < min_val) min_val = blue;
      s1_delta_in = s1_max_in - min_val;
   end

   always_ff @(posedge clock) begin
      s1_max_ff    <= s1_max_in;
      s1_delta_ff  <= s1_delta_in;
      s1_sector_ff <= s1_sector_in;
      s1_diff_ff   <= s1_diff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   // Pick the sector base, wrapping a negative red-sector hue by a full turn
   always_comb begin
      unique case (s1_sector_ff)
         rhsv_pkg::SECT_RED: begin
            base = s1_diff_ff[rhsv_pkg::COMP_W] ?
                   rhsv_pkg::NUM_W'(rhsv_pkg::NUM_W'(s1_delta_ff) * rhsv_pkg::HUE_RED_WRAP) :
                   '0;
         end
         rhsv_pkg::SECT_GREEN: begin
            base = rhsv_pkg::NUM_W'(rhsv_pkg::NUM_W'(s1_delta_ff) * rhsv_pkg::HUE_GREEN_BASE);
         end
         default: begin
            base = rhsv_pkg::NUM_W'(rhsv_pkg::NUM_W'(s1_delta_ff) * rhsv_pkg::HUE_BLUE_BASE);
         end
      endcase
   end

   // Form both dividends; the hue sum is never negative
   always_comb begin
      diff_x      = 16'(s1_diff_ff);
      diff_scaled = diff_x * rhsv_pkg::HUE_SECTOR;
      hue_sum     = $signed({1'b0, base}) + (rhsv_pkg::NUM_W+1)'(diff_scaled);
      hue_num     = hue_sum[rhsv_pkg::NUM_W-1:0];
      sat_num     = {1'b0, s1_delta_ff, {rhsv_pkg::COMP_W{1'b0}}} -
                    rhsv_pkg::NUM_W'(s1_delta_ff);

      s2_in.valid      = s1_valid_ff;
      s2_in.grey       = (s1_delta_ff == '0);
      s2_in.brightness = s1_max_ff;
      s2_in.hue        = rhsv_pkg::div_load(hue_num, s1_delta_ff);
      s2_in.sat        = rhsv_pkg::div_load(sat_num, s1_max_ff);
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_comb begin
      out       = s2_ff;
      out.valid = s2_valid_ff;
   end

endmodule

@@ design/rhsv_div_stage.sv @@
module rhsv_div_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  rhsv_pkg::div_pipe_type  in,
   output rhsv_pkg::div_pipe_type  out
);

   logic                    valid_ff;
   rhsv_pkg::div_pipe_type  data_ff, data_in;

   // Advance both quotients by DIV_STEPS bits each
   always_comb begin
      data_in = in;
      for (int i = 0; i < rhsv_pkg::DIV_STEPS; i++) begin
         data_in.hue = rhsv_pkg::div_step(data_in.hue);
         data_in.sat = rhsv_pkg::div_step(data_in.sat);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in.valid;
      end
   end

   always_comb begin
      out       = data_ff;
      out.valid = valid_ff;
   end

endmodule

@@ design/rhsv_checker.sv @@
`include "assert_macros.svh"

module rhsv_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [rhsv_pkg::COMP_W-1:0]   req_red,
   input logic [rhsv_pkg::COMP_W-1:0]   req_green,
   input logic [rhsv_pkg::COMP_W-1:0]   req_blue,
   input logic                          rsp_valid,
   input logic [rhsv_pkg::HUE_W-1:0]    rsp_hue,
   input logic [rhsv_pkg::COMP_W-1:0]   rsp_saturation,
   input logic [rhsv_pkg::COMP_W-1:0]   rsp_brightness
);

   // Two front stages plus the divider stages
   localparam int LATENCY = 2 + rhsv_pkg::DIV_STAGES;

   logic [rhsv_pkg::COMP_W-1:0] req_max;

   // Track the largest component of the request
   always_comb begin
      req_max = req_red;
      if (req_green > req_max) req_max = req_green;
      if (req_blue > req_max) req_max = req_blue;
   end

   // Every accepted transaction is answered once through the front and divider stages
   `ASSERT_PROP(a_rsp_follows_req, start && !busy |-> ##LATENCY rsp_valid)
   `ASSERT_PROP(a_rsp_has_req, rsp_valid |-> $past(start && !busy, LATENCY))

   // Brightness is the largest of the components of the matching request
   `ASSERT_PROP(a_brightness_max, rsp_valid |-> rsp_brightness == $past(req_max, LATENCY))

   // Black is grey: hue and saturation are zero
   `ASSERT_PROP(a_black_zero, rsp_valid && rsp_brightness == '0 |-> rsp_hue == '0 && rsp_saturation == '0)

   // Hue stays below a full turn
   `ASSERT_NEVER(a_hue_range, rsp_valid && rsp_hue >= 9'd360)

endmodule

bind rgb_to_hsv_pixel_top rhsv_checker u_checker (.*);
